/* sv/rla_pkg.sv */
package rla_pkg;

  // Ring and device sizing.
  localparam int RING_DEPTH   = 4;
  localparam int LEASE_TICKS  = 3;
  localparam int DEVICE_COUNT = 3;
  localparam int DEV_BASE     = 3;
  localparam int IDX_W        = $clog2(RING_DEPTH);
  localparam int DSEL_W       = (DEVICE_COUNT > 1) ? $clog2(DEVICE_COUNT) : 1;

  typedef logic [IDX_W-1:0]  idx_t;
  typedef logic [DSEL_W-1:0] dsel_t;
  typedef logic [2:0]        slot_t;
  typedef logic signed [2:0] timer_t;
  typedef logic [1:0]        mode_t;
  typedef logic [1:0]        msg_t;

  // Controller modes. A controller id of 0 or 3 may leave a mode of 0 or 3 in place.
  localparam mode_t MODE_UNINIT  = 2'd0;
  localparam mode_t MODE_ACTIVE  = 2'd1;
  localparam mode_t MODE_STANDBY = 2'd2;

  // Device message codes.
  localparam msg_t MSG_NONE    = 2'd0;
  localparam msg_t MSG_ACQUIRE = 2'd1;
  localparam msg_t MSG_RELEASE = 2'd2;

  localparam timer_t TIMER_NONE = -3'sd1;

  typedef enum logic [2:0] {
    OP_WAIT,
    OP_MODE,
    OP_COPY,
    OP_DEV_START,
    OP_SCAN,
    OP_DEV_NEXT,
    OP_AGE,
    OP_EMIT
  } op_t;

  typedef enum logic [2:0] {
    COND_NONE,
    COND_NO_ITEM,
    COND_NO_COPY,
    COND_COPY_MORE,
    COND_NOT_ACQ,
    COND_SCAN_MORE,
    COND_MORE_DEV,
    COND_OUT_BUSY
  } cond_t;

  typedef logic [2:0] pc_t;

  typedef struct packed {
    op_t   op;
    cond_t cond;
    pc_t   target;
  } ucode_t;

  // Flags the datapath reports back for conditional jumps.
  typedef struct packed {
    logic no_item;
    logic no_copy;
    logic copy_more;
    logic not_acq;
    logic scan_more;
    logic more_dev;
    logic out_busy;
  } status_t;

endpackage

/* sv/rla_ifs.sv */
interface rla_in_if;
  logic        valid;
  logic        ready;
  logic        console_toggle;
  logic        peer_heartbeat_seen;
  logic [1:0]  peer_mode;
  logic [2:0]  peer_timer;
  logic [7:0]  peer_head;
  logic [7:0]  peer_tail;
  logic [31:0] peer_slots;
  logic [1:0]  dev_a_msg;
  logic [1:0]  dev_b_msg;
  logic [1:0]  dev_c_msg;

  modport source (
    output valid, console_toggle, peer_heartbeat_seen, peer_mode, peer_timer,
           peer_head, peer_tail, peer_slots, dev_a_msg, dev_b_msg, dev_c_msg,
    input  ready
  );
  modport sink (
    input  valid, console_toggle, peer_heartbeat_seen, peer_mode, peer_timer,
           peer_head, peer_tail, peer_slots, dev_a_msg, dev_b_msg, dev_c_msg,
    output ready
  );
endinterface

interface rla_out_if;
  logic        valid;
  logic        ready;
  logic        grant_valid;
  logic [2:0]  grant_device;
  logic [1:0]  hb_mode;
  logic [2:0]  hb_timer;
  logic [1:0]  hb_head;
  logic [1:0]  hb_tail;
  logic [31:0] hb_slots;

  modport source (
    output valid, grant_valid, grant_device, hb_mode, hb_timer, hb_head, hb_tail,
           hb_slots,
    input  ready
  );
  modport sink (
    input  valid, grant_valid, grant_device, hb_mode, hb_timer, hb_head, hb_tail,
           hb_slots,
    output ready
  );
endinterface

interface rla_cfg_if;
  logic       valid;
  logic       ready;
  logic [1:0] controller_id;

  modport source (output valid, controller_id, input ready);
  modport sink (input valid, controller_id, output ready);
endinterface

/* sv/redundant_lease_arbiter_step.sv */
// Channel    | Direction | Carries
// inbox      | sink      | one period's inbox: console toggle, peer heartbeat, device messages
// heartbeat  | source    | grant and the controller's full state after the period
// cfg        | sink      | controller_id write, ready whenever reset is low
//
// An item passes through a wait step, a mode step, a peer-copy step when a peer heartbeat
// is adopted with indices in range, per device a start and a next step with a ring scan
// for each acquire, then aging and an output step that a heartbeat stall holds.
// The ring is walked one slot per cycle. Reset is synchronous and returns the
// controller to uninit with an empty ring and controller_id 1; no item is taken in reset.
// A stalled heartbeat holds the output step; the next item is taken once it is loaded.
module redundant_lease_arbiter_step import rla_pkg::*; (
  input  logic      clk,
  input  logic      rst,
  rla_in_if.sink    inbox,
  rla_out_if.source heartbeat,
  rla_cfg_if.sink   cfg
);

  // Configuration register: users write it only while the block is idle; not enforced.
  logic [1:0] controller_id;

  ucode_t  uc;
  status_t st;

  assign cfg.ready = !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      controller_id <= 2'd1;
    end else if (cfg.valid) begin
      controller_id <= cfg.controller_id;
    end
  end

  // The sequencer holds the step counter and the program store; each control
  // word selects one datapath operation and an optional conditional jump.
  rla_seq u_seq (
    .clk (clk),
    .rst (rst),
    .st  (st),
    .uc  (uc)
  );

  // The datapath holds the mode, lease timer, ring and the result register.
  rla_dp u_dp (
    .clk           (clk),
    .rst           (rst),
    .controller_id (controller_id),
    .uc            (uc),
    .st            (st),
    .inbox         (inbox),
    .heartbeat     (heartbeat)
  );

endmodule

/* sv/rla_seq.sv */
module rla_seq import rla_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  status_t st,
  output ucode_t  uc
);

  localparam pc_t STEP_WAIT  = 3'd0;
  localparam pc_t STEP_MODE  = 3'd1;
  localparam pc_t STEP_COPY  = 3'd2;
  localparam pc_t STEP_DEV   = 3'd3;
  localparam pc_t STEP_SCAN  = 3'd4;
  localparam pc_t STEP_NEXT  = 3'd5;
  localparam pc_t STEP_AGE   = 3'd6;
  localparam pc_t STEP_EMIT  = 3'd7;

  pc_t  pc;
  pc_t  pc_next;
  logic jump;

  // Program store: one control word per step.
  always_comb begin
    case (pc)
      STEP_WAIT: uc = '{op: OP_WAIT,      cond: COND_NO_ITEM,   target: STEP_WAIT};
      STEP_MODE: uc = '{op: OP_MODE,      cond: COND_NO_COPY,   target: STEP_DEV};
      STEP_COPY: uc = '{op: OP_COPY,      cond: COND_COPY_MORE, target: STEP_COPY};
      STEP_DEV:  uc = '{op: OP_DEV_START, cond: COND_NOT_ACQ,   target: STEP_NEXT};
      STEP_SCAN: uc = '{op: OP_SCAN,      cond: COND_SCAN_MORE, target: STEP_SCAN};
      STEP_NEXT: uc = '{op: OP_DEV_NEXT,  cond: COND_MORE_DEV,  target: STEP_DEV};
      STEP_AGE:  uc = '{op: OP_AGE,       cond: COND_NONE,      target: STEP_WAIT};
      STEP_EMIT: uc = '{op: OP_EMIT,      cond: COND_OUT_BUSY,  target: STEP_EMIT};
      default:   uc = '{op: OP_WAIT,      cond: COND_NONE,      target: STEP_WAIT};
    endcase
  end

  always_comb begin
    case (uc.cond)
      COND_NONE:      jump = 1'b0;
      COND_NO_ITEM:   jump = st.no_item;
      COND_NO_COPY:   jump = st.no_copy;
      COND_COPY_MORE: jump = st.copy_more;
      COND_NOT_ACQ:   jump = st.not_acq;
      COND_SCAN_MORE: jump = st.scan_more;
      COND_MORE_DEV:  jump = st.more_dev;
      COND_OUT_BUSY:  jump = st.out_busy;
      default:        jump = 1'b0;
    endcase
  end

  // The program wraps from the last step back to the wait step.
  always_comb begin
    if (jump) begin
      pc_next = uc.target;
    end else begin
      pc_next = pc + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= STEP_WAIT;
    end else begin
      pc <= pc_next;
    end
  end

endmodule

/* sv/rla_dp.sv */
module rla_dp import rla_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic [1:0]   controller_id,
  input  ucode_t       uc,
  output status_t      st,
  rla_in_if.sink       inbox,
  rla_out_if.source    heartbeat
);

  function automatic idx_t ring_next(input idx_t i);
    idx_t r;
    if (i == idx_t'(RING_DEPTH - 1)) begin
      r = '0;
    end else begin
      r = i + idx_t'(1);
    end
    return r;
  endfunction

  // Latched item.
  logic        con_q;
  logic        hb_q;
  timer_t      ptimer_q;
  logic [7:0]  phead_q;
  logic [7:0]  ptail_q;
  logic [31:0] pslots_q;
  msg_t        msg_q [DEVICE_COUNT];

  // Controller state.
  mode_t  mode;
  timer_t timer;
  idx_t   head;
  idx_t   tail;
  slot_t  slots [RING_DEPTH];

  // Sequencing registers.
  idx_t   ptr;
  dsel_t  dsel;

  // Result register.
  logic        out_valid;
  logic        out_grant_valid;
  slot_t       out_grant_device;
  mode_t       out_mode;
  timer_t      out_timer;
  idx_t        out_head;
  idx_t        out_tail;
  logic [31:0] out_slots;

  idx_t        rd_addr;
  slot_t       rd;
  msg_t        msg;
  slot_t       dev_id;
  logic [7:0]  peer_byte;
  logic        peer_ok;
  logic        range_ok;
  logic        do_copy;
  logic        grant_ok;
  logic        out_busy;
  logic [31:0] packed_slots;

  always_comb begin
    rd_addr   = (uc.op == OP_SCAN) ? ptr : head;
    rd        = slots[rd_addr];
    msg       = msg_q[dsel];
    dev_id    = slot_t'(DEV_BASE) + slot_t'(dsel);
    peer_byte = pslots_q[8*ptr +: 8];
    peer_ok   = (peer_byte >= 8'(DEV_BASE)) && (peer_byte < 8'(DEV_BASE + DEVICE_COUNT));
    range_ok  = !phead_q[7] && (phead_q < 8'(RING_DEPTH)) &&
                !ptail_q[7] && (ptail_q < 8'(RING_DEPTH));
    do_copy   = (mode != MODE_ACTIVE) && hb_q;
    grant_ok  = (mode == MODE_ACTIVE) && timer[2] && (rd != '0);
    out_busy  = out_valid && !heartbeat.ready;
  end

  always_comb begin
    st.no_item   = !inbox.valid;
    st.no_copy   = !(do_copy && range_ok);
    st.copy_more = (ptr != ptail_q[IDX_W-1:0]) && peer_ok;
    st.not_acq   = (msg != MSG_ACQUIRE);
    st.scan_more = (ptr != tail) && (rd != dev_id);
    st.more_dev  = (dsel != dsel_t'(DEVICE_COUNT - 1));
    st.out_busy  = out_busy;
  end

  always_comb begin
    packed_slots = '0;
    for (int i = 0; i < RING_DEPTH && i < 4; i++) begin
      packed_slots[8*i +: 8] = {5'b0, slots[i]};
    end
  end

  assign inbox.ready = (uc.op == OP_WAIT) && !rst;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode      <= MODE_UNINIT;
      timer     <= '0;
      head      <= '0;
      tail      <= '0;
      ptr       <= '0;
      dsel      <= '0;
      out_valid <= 1'b0;
      for (int i = 0; i < RING_DEPTH; i++) begin
        slots[i] <= '0;
      end
    end else begin
      if (out_valid && heartbeat.ready && uc.op != OP_EMIT) begin
        out_valid <= 1'b0;
      end
      case (uc.op)
        OP_WAIT: begin
          if (inbox.valid) begin
            con_q    <= inbox.console_toggle;
            hb_q     <= inbox.peer_heartbeat_seen;
            ptimer_q <= timer_t'(inbox.peer_timer);
            phead_q  <= inbox.peer_head;
            ptail_q  <= inbox.peer_tail;
            pslots_q <= inbox.peer_slots;
            msg_q[0] <= inbox.dev_a_msg;
            msg_q[1] <= inbox.dev_b_msg;
            msg_q[2] <= inbox.dev_c_msg;
          end
        end
        OP_MODE: begin
          dsel <= '0;
          if (mode == MODE_ACTIVE) begin
            if (hb_q && con_q) begin
              mode <= MODE_STANDBY;
            end
          end else if (hb_q) begin
            mode  <= (mode == MODE_STANDBY && con_q) ? MODE_ACTIVE : MODE_STANDBY;
            timer <= ptimer_q;
            head  <= '0;
            tail  <= '0;
            ptr   <= phead_q[IDX_W-1:0];
          end else if (mode == MODE_STANDBY) begin
            mode <= MODE_ACTIVE;
          end else begin
            mode  <= controller_id;
            timer <= TIMER_NONE;
          end
        end
        OP_COPY: begin
          if (ptr == ptail_q[IDX_W-1:0]) begin
            head <= phead_q[IDX_W-1:0];
            tail <= ptail_q[IDX_W-1:0];
          end else if (peer_ok) begin
            slots[ptr] <= peer_byte[2:0];
            ptr        <= ring_next(ptr);
          end
        end
        OP_DEV_START: begin
          ptr <= head;
          if (msg == MSG_RELEASE && rd == dev_id && !timer[2] &&
              timer < timer_t'(LEASE_TICKS)) begin
            timer <= '0;
          end
        end
        OP_SCAN: begin
          if (ptr == tail) begin
            slots[tail] <= dev_id;
            tail        <= ring_next(tail);
          end else if (rd != dev_id) begin
            ptr <= ring_next(ptr);
          end
        end
        OP_DEV_NEXT: begin
          if (st.more_dev) begin
            dsel <= dsel + dsel_t'(1);
          end
        end
        OP_AGE: begin
          if (timer == '0) begin
            timer <= TIMER_NONE;
            head  <= ring_next(head);
          end else if (!timer[2]) begin
            timer <= timer - timer_t'(1);
          end
        end
        OP_EMIT: begin
          if (!out_busy) begin
            out_valid   <= 1'b1;
            out_mode    <= mode;
            out_head    <= head;
            out_tail    <= tail;
            out_slots   <= packed_slots;
            if (grant_ok) begin
              timer            <= timer_t'(LEASE_TICKS);
              out_timer        <= timer_t'(LEASE_TICKS);
              out_grant_valid  <= 1'b1;
              out_grant_device <= rd;
            end else begin
              out_timer        <= timer;
              out_grant_valid  <= 1'b0;
              out_grant_device <= '0;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  assign heartbeat.valid        = out_valid;
  assign heartbeat.grant_valid  = out_grant_valid;
  assign heartbeat.grant_device = out_grant_device;
  assign heartbeat.hb_mode      = out_mode;
  assign heartbeat.hb_timer     = out_timer;
  assign heartbeat.hb_head      = out_head;
  assign heartbeat.hb_tail      = out_tail;
  assign heartbeat.hb_slots     = out_slots;

endmodule

/* sim/redundant_lease_arbiter_step_tb.sv */
`timescale 1ns / 100ps

module redundant_lease_arbiter_step_tb import rla_pkg::*;;

  // The one message code that the package leaves unnamed: the block ignores it.
  localparam msg_t MSG_IGNORED = 2'd3;

  // One period's inbox as the testbench sees it.
  typedef struct {
    logic              con;
    logic              hb;
    logic [1:0]        pmode;
    logic signed [2:0] ptimer;
    logic signed [7:0] phead;
    logic signed [7:0] ptail;
    logic [31:0]       pslots;
    msg_t [2:0]        dev_msg;
  } inbox_t;

  // One heartbeat item. The timer is kept unsigned here so that the expected
  // and the sampled value compare bit for bit.
  typedef struct {
    logic        grant_valid;
    logic [2:0]  grant_device;
    logic [1:0]  mode;
    logic [2:0]  timer;
    logic [1:0]  head;
    logic [1:0]  tail;
    logic [31:0] slots;
  } beat_t;

  // Lease controller model plus the queue of heartbeats it still owes.
  class lease_scoreboard;
    logic [1:0]  controller_id;
    mode_t       ctrl_mode;
    timer_t      lease;
    idx_t        head;
    idx_t        tail;
    slot_t       ring [RING_DEPTH];
    beat_t       expected_beats [$];
    int unsigned mismatches;

    function new();
      controller_id = 2'd1;
      ctrl_mode     = MODE_UNINIT;
      lease         = '0;
      head          = '0;
      tail          = '0;
      foreach (ring[i]) ring[i] = '0;
      mismatches    = 0;
    endfunction

    function void set_controller_id(logic [1:0] id);
      controller_id = id;
    endfunction

    function int pending();
      return expected_beats.size();
    endfunction

    function idx_t ring_next(idx_t c);
      return (int'(c) == RING_DEPTH - 1) ? idx_t'(0) : idx_t'(c + 1'b1);
    endfunction

    function bit device_id_ok(logic [7:0] v);
      return (v >= DEV_BASE) && (v < DEV_BASE + DEVICE_COUNT);
    endfunction

    // Take over the peer's state. The timer is trusted as is; the ring span is
    // only adopted when both indices and every entry in it are valid.
    function void adopt_peer(inbox_t it);
      int         h;
      int         t;
      idx_t       c;
      logic [7:0] v;
      h     = it.phead;
      t     = it.ptail;
      lease = it.ptimer;
      head  = '0;
      tail  = '0;
      if (h < 0 || h >= RING_DEPTH || t < 0 || t >= RING_DEPTH) return;
      c = idx_t'(h);
      while (c != idx_t'(t)) begin
        v = it.pslots[8 * int'(c) +: 8];
        if (!device_id_ok(v)) return;
        ring[c] = v[2:0];
        c = ring_next(c);
      end
      head = idx_t'(h);
      tail = idx_t'(t);
    endfunction

    function void enqueue_device(slot_t id);
      idx_t c;
      c = head;
      while (c != tail) begin
        if (ring[c] == id) return;
        c = ring_next(c);
      end
      ring[tail] = id;
      tail = ring_next(tail);
    endfunction

    function void release_device(slot_t id);
      if (ring[head] == id && lease >= 0 && lease < LEASE_TICKS) lease = '0;
    endfunction

    // Run one control period and queue the heartbeat it produces.
    function void note_inbox(inbox_t it);
      mode_t was;
      slot_t grant;
      beat_t beat;
      grant = '0;
      if (ctrl_mode == MODE_ACTIVE) begin
        if (it.hb && it.con) ctrl_mode = MODE_STANDBY;
      end else if (it.hb) begin
        was = ctrl_mode;
        adopt_peer(it);
        ctrl_mode = (was == MODE_STANDBY && it.con) ? MODE_ACTIVE : MODE_STANDBY;
      end else if (ctrl_mode == MODE_STANDBY) begin
        ctrl_mode = MODE_ACTIVE;
      end else begin
        ctrl_mode = controller_id;
        lease     = TIMER_NONE;
      end
      for (int i = 0; i < DEVICE_COUNT && i < 3; i++) begin
        if (it.dev_msg[i] == MSG_ACQUIRE) enqueue_device(slot_t'(DEV_BASE + i));
        else if (it.dev_msg[i] == MSG_RELEASE) release_device(slot_t'(DEV_BASE + i));
      end
      if (lease > 0) begin
        lease = lease - timer_t'(1);
      end else if (lease == 0) begin
        lease = TIMER_NONE;
        head  = ring_next(head);
      end
      if (ctrl_mode == MODE_ACTIVE && lease < 0 && ring[head] != 0) begin
        lease = timer_t'(LEASE_TICKS);
        grant = ring[head];
      end
      beat.grant_valid  = (grant != 0);
      beat.grant_device = grant;
      beat.mode         = ctrl_mode;
      beat.timer        = lease;
      beat.head         = head;
      beat.tail         = tail;
      beat.slots        = '0;
      for (int i = 0; i < RING_DEPTH && i < 4; i++) beat.slots[8 * i +: 8] = {5'b0, ring[i]};
      expected_beats.push_back(beat);
    endfunction

    function void check_field(string name, logic [31:0] exp, logic [31:0] got);
      if (exp !== got) begin
        $error("%s: expected 0x%0h, got 0x%0h", name, exp, got);
        mismatches++;
      end
    endfunction

    function void check_heartbeat(beat_t got);
      beat_t exp;
      if (expected_beats.size() == 0) begin
        $error("heartbeat item arrived with no expected result waiting");
        mismatches++;
        return;
      end
      exp = expected_beats.pop_front();
      check_field("grant_valid", exp.grant_valid, got.grant_valid);
      check_field("grant_device", exp.grant_device, got.grant_device);
      check_field("hb_mode", exp.mode, got.mode);
      check_field("hb_timer", exp.timer, got.timer);
      check_field("hb_head", exp.head, got.head);
      check_field("hb_tail", exp.tail, got.tail);
      check_field("hb_slots", exp.slots, got.slots);
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst;

  // When set, neither side inserts idle cycles, so back-to-back items occur.
  bit no_idle;

  lease_scoreboard store;

  rla_in_if  inbox_ch ();
  rla_out_if heartbeat_ch ();
  rla_cfg_if cfg_ch ();

  redundant_lease_arbiter_step dut (
    .clk       (clk),
    .rst       (rst),
    .inbox     (inbox_ch),
    .heartbeat (heartbeat_ch),
    .cfg       (cfg_ch)
  );

  always #1 clk = ~clk;

  // Every block input gets a known value at time zero; reset starts asserted and is then released.
  initial begin
    rst                          <= 1'b1;
    inbox_ch.valid               <= 1'b0;
    inbox_ch.console_toggle      <= 1'b0;
    inbox_ch.peer_heartbeat_seen <= 1'b0;
    inbox_ch.peer_mode           <= '0;
    inbox_ch.peer_timer          <= '0;
    inbox_ch.peer_head           <= '0;
    inbox_ch.peer_tail           <= '0;
    inbox_ch.peer_slots          <= '0;
    inbox_ch.dev_a_msg           <= MSG_NONE;
    inbox_ch.dev_b_msg           <= MSG_NONE;
    inbox_ch.dev_c_msg           <= MSG_NONE;
    heartbeat_ch.ready           <= 1'b0;
    cfg_ch.valid                 <= 1'b0;
    cfg_ch.controller_id         <= 2'd1;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
  end

  // A hung handshake ends the run here. The slowest legal run is well under
  // 50 us, so this leaves a wide margin.
  initial begin
    #500000;
    $display("redundant_lease_arbiter_step_tb: FAIL");
    $finish;
  end

  // Present one inbox item after a random number of idle cycles and hold it
  // until the block takes it. Valid is left high afterwards, so that a
  // following item with no gap keeps it high without a glitch; the next gap,
  // or the caller, lowers it.
  task automatic send_inbox(input inbox_t it);
    int unsigned gap;
    gap = no_idle ? 0 : $urandom_range(0, 5);
    if (gap > 0) begin
      inbox_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    inbox_ch.valid               <= 1'b1;
    inbox_ch.console_toggle      <= it.con;
    inbox_ch.peer_heartbeat_seen <= it.hb;
    inbox_ch.peer_mode           <= it.pmode;
    inbox_ch.peer_timer          <= it.ptimer;
    inbox_ch.peer_head           <= it.phead;
    inbox_ch.peer_tail           <= it.ptail;
    inbox_ch.peer_slots          <= it.pslots;
    inbox_ch.dev_a_msg           <= it.dev_msg[0];
    inbox_ch.dev_b_msg           <= it.dev_msg[1];
    inbox_ch.dev_c_msg           <= it.dev_msg[2];
    @(posedge clk);
    while (!inbox_ch.ready) @(posedge clk);
    store.note_inbox(it);
  endtask

  function automatic inbox_t inbox_of(logic con, logic hb, logic [1:0] pmode, int ptimer,
                                      int phead, int ptail, logic [31:0] pslots,
                                      msg_t a, msg_t b, msg_t c);
    inbox_t it;
    it.con        = con;
    it.hb         = hb;
    it.pmode      = pmode;
    it.ptimer     = timer_t'(ptimer);
    it.phead      = 8'(phead);
    it.ptail      = 8'(ptail);
    it.pslots     = pslots;
    it.dev_msg[0] = a;
    it.dev_msg[1] = b;
    it.dev_msg[2] = c;
    return it;
  endfunction

  // Device messages lean toward acquire and release so the ring keeps moving.
  function automatic msg_t pick_msg();
    int unsigned r;
    r = $urandom_range(0, 9);
    if (r < 3) return MSG_NONE;
    if (r < 6) return MSG_ACQUIRE;
    if (r < 9) return MSG_RELEASE;
    return MSG_IGNORED;
  endfunction

  // Mostly well-formed peer heartbeats (indices in range, slots holding real
  // device ids) so that the copy runs to completion, with some noise mixed in
  // to hit the early exits of the copy.
  function automatic inbox_t random_inbox();
    inbox_t it;
    it.con    = ($urandom_range(0, 3) == 0);
    it.hb     = ($urandom_range(0, 9) < 4);
    it.pmode  = 2'($urandom_range(0, 2));
    it.ptimer = timer_t'(int'($urandom_range(0, 4)) - 1);
    it.phead  = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 3)) : 8'($urandom);
    it.ptail  = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(0, 3)) : 8'($urandom);
    for (int i = 0; i < 4; i++) begin
      it.pslots[8 * i +: 8] = ($urandom_range(0, 19) < 17) ?
                              8'($urandom_range(DEV_BASE, DEV_BASE + DEVICE_COUNT - 1)) :
                              8'($urandom_range(0, 255));
    end
    for (int i = 0; i < 3; i++) it.dev_msg[i] = pick_msg();
    return it;
  endfunction

  // Drop valid and hold off until every heartbeat owed has come back. Each
  // inbox item yields exactly one heartbeat, so the block is idle after that.
  task automatic drain_heartbeats();
    inbox_ch.valid <= 1'b0;
    while (store.pending() != 0) @(posedge clk);
  endtask

  // The id register is only ever written while the block is idle.
  task automatic write_controller_id(input logic [1:0] id);
    drain_heartbeats();
    cfg_ch.valid         <= 1'b1;
    cfg_ch.controller_id <= id;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    store.set_controller_id(id);
  endtask

  // Heartbeat side: a random stall before each item, then take it and check it.
  // Fields are sampled right after the edge, so they hold the values that were
  // present when the handshake happened.
  initial begin
    int unsigned gap;
    beat_t       got;
    while (rst !== 1'b0) @(posedge clk);
    forever begin
      gap = no_idle ? 0 : $urandom_range(0, 5);
      if (gap > 0) begin
        heartbeat_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      heartbeat_ch.ready <= 1'b1;
      @(posedge clk);
      while (heartbeat_ch.valid !== 1'b1) @(posedge clk);
      got.grant_valid  = heartbeat_ch.grant_valid;
      got.grant_device = heartbeat_ch.grant_device;
      got.mode         = heartbeat_ch.hb_mode;
      got.timer        = heartbeat_ch.hb_timer;
      got.head         = heartbeat_ch.hb_head;
      got.tail         = heartbeat_ch.hb_tail;
      got.slots        = heartbeat_ch.hb_slots;
      store.check_heartbeat(got);
    end
  end

  initial begin
    logic [1:0] phase_ids [4];
    store     = new();
    no_idle   = 1'b0;
    phase_ids = '{2'd2, 2'd1, 2'd0, 2'd2};
    while (rst !== 1'b0) @(posedge clk);

    // Directed part. An id of 0 leaves an uninitialized controller in a mode
    // that never grants, even with devices queued. The peer fields carry their
    // extremes here; without a heartbeat they must have no effect.
    write_controller_id(2'd0);
    send_inbox(inbox_of(1'b0, 1'b0, 2'd2, 3, -128, 127, 32'hffff_ffff,
                        MSG_ACQUIRE, MSG_NONE, MSG_NONE));
    send_inbox(inbox_of(1'b1, 1'b0, 2'd0, -1, 0, 0, 32'h0000_0000,
                        MSG_IGNORED, MSG_IGNORED, MSG_IGNORED));

    // An id of 3 is just as inert. A duplicate acquire is dropped, and a
    // release from a device that is not at the head is refused.
    write_controller_id(2'd3);
    send_inbox(inbox_of(1'b0, 1'b0, 2'd1, 0, 1, 2, 32'h0504_0300,
                        MSG_NONE, MSG_ACQUIRE, MSG_ACQUIRE));
    send_inbox(inbox_of(1'b0, 1'b0, 2'd1, 0, 0, 0, 32'h0000_0000,
                        MSG_ACQUIRE, MSG_RELEASE, MSG_NONE));

    // Id 1 makes the controller active and it grants to the head device at
    // once. A release with a fresh lease is refused; one tick later it is
    // honored, the lease ages out, and the next device gets the grant.
    write_controller_id(2'd1);
    send_inbox(inbox_of(1'b0, 1'b0, 2'd0, 0, 0, 0, 32'h0000_0000,
                        MSG_NONE, MSG_NONE, MSG_NONE));
    send_inbox(inbox_of(1'b0, 1'b0, 2'd0, 0, 0, 0, 32'h0000_0000,
                        MSG_RELEASE, MSG_NONE, MSG_NONE));
    send_inbox(inbox_of(1'b0, 1'b0, 2'd0, 0, 0, 0, 32'h0000_0000,
                        MSG_RELEASE, MSG_NONE, MSG_NONE));

    // Heartbeat plus toggle while active: step down to standby, peer state unused.
    send_inbox(inbox_of(1'b1, 1'b1, 2'd1, 2, 1, 3, 32'h0304_0503,
                        MSG_ACQUIRE, MSG_NONE, MSG_NONE));
    // Standby copies: head out of range, then tail out of range; only the
    // timer comes across and the indices fall back to zero.
    send_inbox(inbox_of(1'b0, 1'b1, 2'd1, -1, -128, 2, 32'h0505_0505,
                        MSG_NONE, MSG_NONE, MSG_NONE));
    send_inbox(inbox_of(1'b0, 1'b1, 2'd1, 1, 0, 127, 32'h0404_0404,
                        MSG_NONE, MSG_ACQUIRE, MSG_NONE));
    // A bad entry in the middle of the span: the good entries before it are
    // kept, the indices stay at zero.
    send_inbox(inbox_of(1'b0, 1'b1, 2'd1, 0, 0, 3, 32'h0007_0403,
                        MSG_NONE, MSG_NONE, MSG_ACQUIRE));
    // A clean copy whose span wraps past the last slot.
    send_inbox(inbox_of(1'b0, 1'b1, 2'd1, 2, 3, 1, 32'h0500_0004,
                        MSG_NONE, MSG_NONE, MSG_NONE));
    // An empty span with a toggle: standby goes active with no owner and
    // grants whatever the head slot of the empty ring still holds.
    send_inbox(inbox_of(1'b1, 1'b1, 2'd2, -1, 2, 2, 32'h0000_0000,
                        MSG_NONE, MSG_NONE, MSG_NONE));
    send_inbox(inbox_of(1'b0, 1'b0, 2'd0, 0, 0, 0, 32'h0000_0000,
                        MSG_ACQUIRE, MSG_ACQUIRE, MSG_ACQUIRE));
    send_inbox(inbox_of(1'b0, 1'b0, 2'd0, 0, 0, 0, 32'h0000_0000,
                        MSG_RELEASE, MSG_RELEASE, MSG_RELEASE));
    send_inbox(inbox_of(1'b0, 1'b0, 2'd0, 0, 0, 0, 32'h0000_0000,
                        MSG_NONE, MSG_NONE, MSG_NONE));
    // Heartbeat without toggle leaves an active controller alone.
    send_inbox(inbox_of(1'b0, 1'b1, 2'd1, 3, 0, 0, 32'hffff_ffff,
                        MSG_RELEASE, MSG_RELEASE, MSG_RELEASE));
    send_inbox(inbox_of(1'b1, 1'b1, 2'd1, 3, 0, 0, 32'h0000_0000,
                        MSG_RELEASE, MSG_RELEASE, MSG_RELEASE));
    // A standby that loses the peer heartbeat takes over.
    send_inbox(inbox_of(1'b0, 1'b0, 2'd0, 0, 0, 0, 32'h0000_0000,
                        MSG_IGNORED, MSG_ACQUIRE, MSG_IGNORED));
    send_inbox(inbox_of(1'b1, 1'b0, 2'd2, -1, 127, -128, 32'hffff_ffff,
                        MSG_ACQUIRE, MSG_RELEASE, MSG_ACQUIRE));

    // Random part in four phases, under the ids 2, 1, 0 and 2 in turn. The sender drains
    // the heartbeats before every id write, which also exercises the block
    // with an empty output path. Idling switches off now and then so that
    // long back-to-back stretches occur as well.
    for (int p = 0; p < 4; p++) begin
      write_controller_id(phase_ids[p]);
      for (int k = 0; k < 100; k++) begin
        if (k % 25 == 0) no_idle = ($urandom_range(0, 3) == 0);
        send_inbox(random_inbox());
      end
    end

    drain_heartbeats();
    // Give any stray heartbeat time to show up before the verdict.
    repeat (40) @(posedge clk);
    if (store.mismatches == 0) begin
      $display("redundant_lease_arbiter_step_tb: PASS");
    end else begin
      $display("redundant_lease_arbiter_step_tb: FAIL");
    end
    $finish;
  end

endmodule
